[sv/periodic_event_scheduler_top_macros.svh]
// ----------------------------------------------------------------------------
// Periodic event scheduler assertion macros
// Shorthands for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_EVENT_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PES_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pes_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic event scheduler package
// Shared types and fixed constants for the scheduler blocks.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int RESULT_LIMIT = 16;
    localparam int NW           = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_TICK       = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_OK        = 3'd0,
        KIND_NO_SPACE  = 3'd1,
        KIND_NOT_FOUND = 3'd2,
        KIND_FIRE      = 3'd3,
        KIND_IDLE      = 3'd4
    } t_kind;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_UPD,
        S_TICK_END
    } t_state;

    typedef struct packed {
        logic [15:0] handler;
        logic [31:0] argument;
        logic [30:0] period;
        logic [31:0] next_due;
    } t_entry;

endpackage

[sv/periodic_event_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Periodic event scheduler
// Ordered table of periodic events: register, unregister and tick commands.
// ----------------------------------------------------------------------------
// Register: writes the new entry at the table end, or reports no space when
// full. Unregister: searches the entries in order, then moves each later entry
// down a slot. Tick: scans the entries, reschedules each due entry, and ends
// the scan at the sixteenth fire. Rate is set by the single table read port
// and the one shared adder; busy stays high until done. Results cannot be stalled.
// Synchronous active-low reset empties the table; entry storage is not cleared.
module periodic_event_scheduler_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_handler,
    input  logic [31:0] i_argument,
    input  logic [30:0] i_period,
    input  logic [31:0] i_now,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [15:0] o_fired_handler,
    output logic [31:0] o_fired_argument,
    output logic        o_last
);
    import pes_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [NW-1:0]   r_nfire, n_nfire;
    logic [15:0]     r_pend_h, n_pend_h;
    logic [31:0]     r_pend_a, n_pend_a;

    logic [15:0]     r_handler;
    logic [31:0]     r_argument;
    logic [30:0]     r_period;
    logic [31:0]     r_now;

    logic            r_strobe, n_strobe;
    logic [2:0]      r_kind, n_kind;
    logic [15:0]     r_fh, n_fh;
    logic [31:0]     r_fa, n_fa;
    logic            r_last, n_last;

    logic            accept;
    logic [CW-1:0]   idx_inc;

    t_alu_op         alu_op;
    logic [31:0]     alu_a, alu_b, alu_y;

    logic            tbl_we, tbl_re;
    logic [AW-1:0]   tbl_waddr, tbl_raddr;
    t_entry          tbl_wdata, tbl_rdata;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign idx_inc = r_idx + CW'(1);

    pes_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    pes_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_nfire  <= n_nfire;
        r_pend_h <= n_pend_h;
        r_pend_a <= n_pend_a;
        r_kind   <= n_kind;
        r_fh     <= n_fh;
        r_fa     <= n_fa;
        r_last   <= n_last;
        if (accept) begin
            r_handler  <= i_handler;
            r_argument <= i_argument;
            r_period   <= i_period;
            r_now      <= i_now;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_nfire   = r_nfire;
        n_pend_h  = r_pend_h;
        n_pend_a  = r_pend_a;
        n_strobe  = 1'b0;
        n_kind    = KIND_OK;
        n_fh      = '0;
        n_fa      = '0;
        n_last    = 1'b1;
        alu_op    = ALU_ADD;
        alu_a     = r_now;
        alu_b     = {1'b0, r_period};
        tbl_we    = 1'b0;
        tbl_waddr = r_count[AW-1:0];
        tbl_wdata = '{handler: r_handler, argument: r_argument,
                      period: r_period, next_due: alu_y};
        tbl_re    = 1'b0;
        tbl_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_idx   = '0;
                n_nfire = '0;
                if (accept) begin
                    case (i_op)
                        OP_REGISTER:   n_state = S_REG;
                        OP_UNREGISTER: n_state = S_FIND_RD;
                        OP_TICK:       n_state = S_TICK_RD;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_REG: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_count >= CW'(MAX_ENTRIES)) begin
                    n_kind = KIND_NO_SPACE;
                end else begin
                    tbl_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            S_FIND_RD: begin
                if (r_idx >= r_count) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    tbl_re  = 1'b1;
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (tbl_rdata.handler == r_handler && tbl_rdata.argument == r_argument) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_FIND_RD;
                end
            end
            S_SHIFT_RD: begin
                if (idx_inc >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    tbl_re    = 1'b1;
                    tbl_raddr = idx_inc[AW-1:0];
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_idx[AW-1:0];
                tbl_wdata = tbl_rdata;
                n_idx     = idx_inc;
                n_state   = S_SHIFT_RD;
            end
            S_TICK_RD: begin
                if (r_idx >= r_count) begin
                    n_state = S_TICK_END;
                end else begin
                    tbl_re  = 1'b1;
                    n_state = S_TICK_EV;
                end
            end
            S_TICK_EV: begin
                alu_op = ALU_SUB;
                alu_a  = tbl_rdata.next_due;
                alu_b  = r_now;
                if (alu_y == 32'd0 || alu_y[31]) begin
                    n_state = S_TICK_UPD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_TICK_RD;
                end
            end
            S_TICK_UPD: begin
                alu_op    = ALU_ADD;
                alu_a     = tbl_rdata.next_due;
                alu_b     = {1'b0, tbl_rdata.period};
                tbl_we    = 1'b1;
                tbl_waddr = r_idx[AW-1:0];
                tbl_wdata = '{handler: tbl_rdata.handler, argument: tbl_rdata.argument,
                              period: tbl_rdata.period, next_due: alu_y};
                // previous fire leaves now that another one follows
                if (r_nfire != '0) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_FIRE;
                    n_fh     = r_pend_h;
                    n_fa     = r_pend_a;
                    n_last   = 1'b0;
                end
                n_pend_h = tbl_rdata.handler;
                n_pend_a = tbl_rdata.argument;
                n_nfire  = r_nfire + NW'(1);
                n_idx    = idx_inc;
                if (r_nfire + NW'(1) == NW'(RESULT_LIMIT)) begin
                    n_state = S_TICK_END;
                end else begin
                    n_state = S_TICK_RD;
                end
            end
            S_TICK_END: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_nfire != '0) begin
                    n_kind = KIND_FIRE;
                    n_fh   = r_pend_h;
                    n_fa   = r_pend_a;
                end else begin
                    n_kind = KIND_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_strobe         = r_strobe;
    assign o_kind           = r_kind;
    assign o_fired_handler  = r_fh;
    assign o_fired_argument = r_fa;
    assign o_last           = r_last;

`include "periodic_event_scheduler_top_macros.svh"

    `PES_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ENTRIES), "entry count above table depth")
    `PES_ASSERT_SAME(a_no_space_full, i_clk, i_rst_n, o_strobe && o_kind == KIND_NO_SPACE, r_count == CW'(MAX_ENTRIES), "no_space with room left")
    `PES_ASSERT_SAME(a_fire_fields, i_clk, i_rst_n, o_strobe && o_kind != KIND_FIRE, o_fired_handler == 16'd0 && o_fired_argument == 32'd0, "fired fields set on non-fire beat")
    `PES_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, accept, !o_strobe, "result beat right after start")

endmodule

[sv/pes_alu.sv]
// ----------------------------------------------------------------------------
// Scheduler shared adder
// One 32-bit wrapping add/subtract unit shared by every time calculation.
// ----------------------------------------------------------------------------
module pes_alu (
    input  pes_pkg::t_alu_op i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic [31:0]      o_y
);
    import pes_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

[sv/pes_table.sv]
// ----------------------------------------------------------------------------
// Scheduler entry table
// Single write port, single registered read port entry memory.
// ----------------------------------------------------------------------------
module pes_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  pes_pkg::t_entry   i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output pes_pkg::t_entry   o_rdata
);
    import pes_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
